[rtl/vcsd_pkg.sv]
`timescale 1ns / 1ps

package vcsd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PSG_TO_AY   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AY_TO_FM    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPN_TO_FM   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_KIND = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_START  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_LIMIT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_ONE    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_TWO    = 3'd7;

    localparam logic [1:0] SRC_OPN2  = 2'd0;
    localparam logic [1:0] SRC_OPN   = 2'd1;
    localparam logic [1:0] SRC_OPNA  = 2'd2;
    localparam logic [1:0] SRC_OTHER = 2'd3;

    localparam logic [15:0] WAIT_ONE_RESET = 16'd735;
    localparam logic [15:0] WAIT_TWO_RESET = 16'd882;

    localparam logic [7:0] OP_PSG       = 8'h50;
    localparam logic [7:0] OP_AY        = 8'hA0;
    localparam logic [7:0] OP_OPN2_P0   = 8'h52;
    localparam logic [7:0] OP_OPN2_P1   = 8'h53;
    localparam logic [7:0] OP_OPM       = 8'h54;
    localparam logic [7:0] OP_OPN       = 8'h55;
    localparam logic [7:0] OP_OPNA_P0   = 8'h56;
    localparam logic [7:0] OP_OPNA_P1   = 8'h57;
    localparam logic [7:0] OP_WAIT_WORD = 8'h61;
    localparam logic [7:0] OP_WAIT_ONE  = 8'h62;
    localparam logic [7:0] OP_WAIT_TWO  = 8'h63;
    localparam logic [7:0] OP_END       = 8'h66;
    localparam logic [3:0] OP_SHORT_HI  = 4'h7;
    localparam logic [3:0] SHORT_MASK   = 4'hF;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_WAIT  = 2'd1;
    localparam logic [1:0] KIND_JUMP  = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    localparam logic [3:0] TGT_PSG       = 4'd0;
    localparam logic [3:0] TGT_PSG_TO_AY = 4'd1;
    localparam logic [3:0] TGT_AY        = 4'd2;
    localparam logic [3:0] TGT_AY_TO_FM  = 4'd3;
    localparam logic [3:0] TGT_OPN2      = 4'd4;
    localparam logic [3:0] TGT_OPM       = 4'd5;
    localparam logic [3:0] TGT_OPN       = 4'd6;
    localparam logic [3:0] TGT_OPNA      = 4'd7;
    localparam logic [3:0] TGT_OPN_TO_FM = 4'd8;

    localparam logic [15:0] PASS_MAX = 16'hFFFF;

    typedef struct packed {
        logic        psg_to_ay_enable;
        logic        ay_to_fm_enable;
        logic        opn_to_fm_enable;
        logic [1:0]  source_chip_kind;
        logic [31:0] loop_start_offset;
        logic [15:0] loop_limit;
        logic [15:0] wait_one_samples;
        logic [15:0] wait_two_samples;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  write_target;
        logic        write_port;
        logic [7:0]  register_address;
        logic [7:0]  register_data;
        logic [15:0] wait_count;
        logic [31:0] jump_offset;
    } t_result;

endpackage

[rtl/vcsd_cfg_regs.sv]
`timescale 1ns / 1ps

module vcsd_cfg_regs
    import vcsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PSG_TO_AY:   n_cfg.psg_to_ay_enable  = i_cfg_data[0];
                CFG_AY_TO_FM:    n_cfg.ay_to_fm_enable   = i_cfg_data[0];
                CFG_OPN_TO_FM:   n_cfg.opn_to_fm_enable  = i_cfg_data[0];
                CFG_SOURCE_KIND: n_cfg.source_chip_kind  = i_cfg_data[1:0];
                CFG_LOOP_START:  n_cfg.loop_start_offset = i_cfg_data[31:0];
                CFG_LOOP_LIMIT:  n_cfg.loop_limit        = i_cfg_data[15:0];
                CFG_WAIT_ONE:    n_cfg.wait_one_samples  = i_cfg_data[15:0];
                CFG_WAIT_TWO:    n_cfg.wait_two_samples  = i_cfg_data[15:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.psg_to_ay_enable  <= 1'b0;
            r_cfg.ay_to_fm_enable   <= 1'b0;
            r_cfg.opn_to_fm_enable  <= 1'b0;
            r_cfg.source_chip_kind  <= SRC_OTHER;
            r_cfg.loop_start_offset <= '0;
            r_cfg.loop_limit        <= '0;
            r_cfg.wait_one_samples  <= WAIT_ONE_RESET;
            r_cfg.wait_two_samples  <= WAIT_TWO_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/vcsd_decoder.sv]
`timescale 1ns / 1ps

module vcsd_decoder
    import vcsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_ended,
    output logic       o_has_result,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_opcode;
    logic [7:0]  n_opcode;
    logic [7:0]  r_operand;
    logic [7:0]  n_operand;
    logic [15:0] r_pass_count;
    logic [15:0] n_pass_count;
    logic        r_stopped;
    logic        n_stopped;

    logic        has;
    t_result     res;
    logic        loop_ok;

    assign loop_ok = (i_cfg.loop_start_offset != '0) &&
                     ((i_cfg.loop_limit == '0) || (r_pass_count < i_cfg.loop_limit));

    always_comb begin
        n_phase      = r_phase;
        n_opcode     = r_opcode;
        n_operand    = r_operand;
        n_pass_count = r_pass_count;
        n_stopped    = r_stopped;
        has          = 1'b0;
        res          = '0;
        if (r_stopped) begin
            has = 1'b0;
        end else if (i_ended) begin
            n_stopped       = 1'b1;
            n_phase         = PH_OPCODE;
            has             = 1'b1;
            res.result_kind = KIND_STOP;
        end else begin
            case (r_phase)
                PH_FIRST: begin
                    if (r_opcode == OP_PSG) begin
                        n_phase           = PH_OPCODE;
                        has               = 1'b1;
                        res.result_kind   = KIND_WRITE;
                        res.write_target  = i_cfg.psg_to_ay_enable ? TGT_PSG_TO_AY : TGT_PSG;
                        res.register_data = i_byte;
                    end else begin
                        n_operand = i_byte;
                        n_phase   = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    n_phase              = PH_OPCODE;
                    has                  = 1'b1;
                    res.result_kind      = KIND_WRITE;
                    res.register_address = r_operand;
                    res.register_data    = i_byte;
                    case (r_opcode)
                        OP_AY: begin
                            res.write_target = i_cfg.ay_to_fm_enable ? TGT_AY_TO_FM : TGT_AY;
                        end
                        OP_OPN2_P0, OP_OPN2_P1: begin
                            res.write_target = (i_cfg.opn_to_fm_enable &&
                                (i_cfg.source_chip_kind == SRC_OPN2)) ? TGT_OPN_TO_FM : TGT_OPN2;
                            res.write_port   = r_opcode[0];
                        end
                        OP_OPM: begin
                            res.write_target = TGT_OPM;
                        end
                        OP_OPN: begin
                            res.write_target = (i_cfg.opn_to_fm_enable &&
                                (i_cfg.source_chip_kind == SRC_OPN)) ? TGT_OPN_TO_FM : TGT_OPN;
                        end
                        OP_OPNA_P0, OP_OPNA_P1: begin
                            res.write_target = (i_cfg.opn_to_fm_enable &&
                                (i_cfg.source_chip_kind == SRC_OPNA)) ? TGT_OPN_TO_FM : TGT_OPNA;
                            res.write_port   = r_opcode[0];
                        end
                        OP_WAIT_WORD: begin
                            res             = '0;
                            res.result_kind = KIND_WAIT;
                            res.wait_count  = {i_byte, r_operand};
                        end
                        default: begin
                            has = 1'b0;
                            res = '0;
                        end
                    endcase
                end
                PH_OPCODE: begin
                    case (i_byte)
                        OP_PSG, OP_AY, OP_OPN2_P0, OP_OPN2_P1, OP_OPM,
                        OP_OPN, OP_OPNA_P0, OP_OPNA_P1, OP_WAIT_WORD: begin
                            n_opcode = i_byte;
                            n_phase  = PH_FIRST;
                        end
                        OP_WAIT_ONE: begin
                            has             = 1'b1;
                            res.result_kind = KIND_WAIT;
                            res.wait_count  = i_cfg.wait_one_samples;
                        end
                        OP_WAIT_TWO: begin
                            has             = 1'b1;
                            res.result_kind = KIND_WAIT;
                            res.wait_count  = i_cfg.wait_two_samples;
                        end
                        OP_END: begin
                            has = 1'b1;
                            if (loop_ok) begin
                                if (r_pass_count < PASS_MAX) begin
                                    n_pass_count = r_pass_count + 16'd1;
                                end
                                res.result_kind = KIND_JUMP;
                                res.jump_offset = i_cfg.loop_start_offset;
                            end else begin
                                n_stopped       = 1'b1;
                                res.result_kind = KIND_STOP;
                            end
                        end
                        default: begin
                            if (i_byte[7:4] == OP_SHORT_HI) begin
                                has             = 1'b1;
                                res.result_kind = KIND_WAIT;
                                res.wait_count  = {12'd0, i_byte[3:0] & SHORT_MASK} + 16'd1;
                            end
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OPCODE;
            r_opcode     <= '0;
            r_operand    <= '0;
            r_pass_count <= 16'd1;
            r_stopped    <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_opcode     <= n_opcode;
            r_operand    <= n_operand;
            r_pass_count <= n_pass_count;
            r_stopped    <= n_stopped;
        end
    end

    assign o_has_result = has;
    assign o_result     = res;

endmodule

[rtl/vgm_command_stream_decoder.sv]
`timescale 1ns / 1ps

// Command stream decoder for VGM sound data.
// The input channel carries one stream word per transfer: a command byte plus a
// flag that marks the end of the available data. The output channel carries at
// most one result per input word: a chip register write, a wait, a loop jump or
// a stop. Both channels use valid and stall; a word moves when valid is high and
// stall is low.
// Each input word is captured in an input register, decoded combinationally and
// written to the output register, so a result becomes valid once its input
// word has passed through both registers. One word is taken per cycle while the
// output side is not stalled; opcode and operand bytes each count as one word.
// When the receiver stalls with a result pending, the input register holds its
// word and the input stall rises; no word or result is lost.
// Synchronous reset empties both registers, restores the register defaults and
// returns the parser to the opcode phase with playback enabled. After a stop,
// further input words are consumed without results until the next reset.
// Configuration registers are written through a simple write port and must only
// change while the block is idle.

module vgm_command_stream_decoder
    import vcsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_stream_byte,
    input  logic                   i_stream_ended,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_result_kind,
    output logic [3:0]             o_write_target,
    output logic                   o_write_port,
    output logic [7:0]             o_register_address,
    output logic [7:0]             o_register_data,
    output logic [15:0]            o_wait_count,
    output logic [31:0]            o_jump_offset
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_ended;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;
    logic       has_result;
    t_result    result;

    vcsd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    vcsd_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_fire       (advance),
        .i_byte       (r_in_byte),
        .i_ended      (r_in_ended),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte  <= i_stream_byte;
            r_in_ended <= i_stream_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_out.result_kind;
    assign o_write_target     = r_out.write_target;
    assign o_write_port       = r_out.write_port;
    assign o_register_address = r_out.register_address;
    assign o_register_data    = r_out.register_data;
    assign o_wait_count       = r_out.wait_count;
    assign o_jump_offset      = r_out.jump_offset;

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output register could take a word");

    a_wait_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == KIND_WAIT)) |->
        ((o_write_target == TGT_PSG) && (o_register_address == 8'd0) &&
         (o_register_data == 8'd0) && (o_jump_offset == 32'd0)))
        else $error("wait result carries write or jump fields");

    a_quiet_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_result_kind == KIND_STOP)) |=> !o_out_valid)
        else $error("result produced after a stop");

endmodule

[tb/tb_vgm_command_stream_decoder.sv]
`timescale 1ns / 1ps

module tb_vgm_command_stream_decoder;
    import vcsd_pkg::*;

    localparam int WORD_TARGET = 1525;
    localparam int TIMEOUT_NS  = 5_000_000;

    localparam logic [7:0] WRITE_OPS [8] = '{OP_PSG, OP_AY, OP_OPN2_P0, OP_OPN2_P1,
                                             OP_OPM, OP_OPN, OP_OPNA_P0, OP_OPNA_P1};

    typedef enum logic [1:0] {AWAIT_OPCODE, AWAIT_FIRST, AWAIT_SECOND} parse_phase_e;

    class vgm_command_decoder_model;
        t_cfg         regs;
        parse_phase_e phase;
        logic [7:0]   held_op;
        logic [7:0]   first_byte;
        logic [15:0]  pass_count;
        bit           stopped;
        t_result      expected_results[$];
        int           mismatches;

        function new();
            regs.psg_to_ay_enable  = 1'b0;
            regs.ay_to_fm_enable   = 1'b0;
            regs.opn_to_fm_enable  = 1'b0;
            regs.source_chip_kind  = SRC_OTHER;
            regs.loop_start_offset = 32'd0;
            regs.loop_limit        = 16'd0;
            regs.wait_one_samples  = WAIT_ONE_RESET;
            regs.wait_two_samples  = WAIT_TWO_RESET;
            phase      = AWAIT_OPCODE;
            held_op    = 8'd0;
            first_byte = 8'd0;
            pass_count = 16'd1;
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_PSG_TO_AY:   regs.psg_to_ay_enable  = v[0];
                CFG_AY_TO_FM:    regs.ay_to_fm_enable   = v[0];
                CFG_OPN_TO_FM:   regs.opn_to_fm_enable  = v[0];
                CFG_SOURCE_KIND: regs.source_chip_kind  = v[1:0];
                CFG_LOOP_START:  regs.loop_start_offset = v;
                CFG_LOOP_LIMIT:  regs.loop_limit        = v[15:0];
                CFG_WAIT_ONE:    regs.wait_one_samples  = v[15:0];
                CFG_WAIT_TWO:    regs.wait_two_samples  = v[15:0];
                default: ;
            endcase
        endfunction

        function bit jump_allowed();
            return regs.loop_start_offset != 32'd0 &&
                   (regs.loop_limit == 16'd0 || pass_count < regs.loop_limit);
        endfunction

        function bit stops_on(logic [7:0] b);
            return !stopped && phase == AWAIT_OPCODE && b == OP_END && !jump_allowed();
        endfunction

        function logic [3:0] route(logic [1:0] kind, logic [3:0] native);
            return (regs.opn_to_fm_enable && regs.source_chip_kind == kind) ?
                   TGT_OPN_TO_FM : native;
        endfunction

        function void note_word(logic [7:0] b, logic ended);
            t_result r;
            bit      hit;
            r   = '0;
            hit = 1'b0;
            if (stopped) return;
            if (ended) begin
                stopped = 1'b1;
                phase = AWAIT_OPCODE;
                r.result_kind = KIND_STOP;
                expected_results.push_back(r);
                return;
            end
            if (phase == AWAIT_FIRST && held_op == OP_PSG) begin
                phase = AWAIT_OPCODE;
                hit = 1'b1;
                r.result_kind = KIND_WRITE;
                r.write_target = regs.psg_to_ay_enable ? TGT_PSG_TO_AY : TGT_PSG;
                r.register_data = b;
            end else if (phase == AWAIT_FIRST) begin
                first_byte = b;
                phase = AWAIT_SECOND;
            end else if (phase == AWAIT_SECOND) begin
                phase = AWAIT_OPCODE;
                hit = 1'b1;
                r.result_kind = KIND_WRITE;
                r.register_address = first_byte;
                r.register_data = b;
                case (held_op)
                    OP_AY: r.write_target = regs.ay_to_fm_enable ? TGT_AY_TO_FM : TGT_AY;
                    OP_OPN2_P0, OP_OPN2_P1: begin
                        r.write_target = route(SRC_OPN2, TGT_OPN2);
                        r.write_port = held_op[0];
                    end
                    OP_OPM: r.write_target = TGT_OPM;
                    OP_OPN: r.write_target = route(SRC_OPN, TGT_OPN);
                    OP_OPNA_P0, OP_OPNA_P1: begin
                        r.write_target = route(SRC_OPNA, TGT_OPNA);
                        r.write_port = held_op[0];
                    end
                    OP_WAIT_WORD: begin
                        r = '0;
                        r.result_kind = KIND_WAIT;
                        r.wait_count = {b, first_byte};
                    end
                    default: hit = 1'b0;
                endcase
            end else begin
                r.result_kind = KIND_WAIT;
                case (b)
                    OP_PSG, OP_AY, OP_OPN2_P0, OP_OPN2_P1, OP_OPM, OP_OPN,
                    OP_OPNA_P0, OP_OPNA_P1, OP_WAIT_WORD: begin
                        held_op = b;
                        phase = AWAIT_FIRST;
                    end
                    OP_WAIT_ONE: begin
                        hit = 1'b1;
                        r.wait_count = regs.wait_one_samples;
                    end
                    OP_WAIT_TWO: begin
                        hit = 1'b1;
                        r.wait_count = regs.wait_two_samples;
                    end
                    OP_END: begin
                        hit = 1'b1;
                        if (jump_allowed()) begin
                            if (pass_count != PASS_MAX) pass_count++;
                            r.result_kind = KIND_JUMP;
                            r.jump_offset = regs.loop_start_offset;
                        end else begin
                            stopped = 1'b1;
                            r.result_kind = KIND_STOP;
                        end
                    end
                    default: begin
                        if (b[7:4] == OP_SHORT_HI) begin
                            hit = 1'b1;
                            r.wait_count = {12'd0, b[3:0]} + 16'd1;
                        end
                    end
                endcase
            end
            if (hit) expected_results.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result of kind %0d", got.result_kind));
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            compare_field("write_target", 32'(got.write_target), 32'(want.write_target));
            compare_field("write_port", 32'(got.write_port), 32'(want.write_port));
            compare_field("register_address", 32'(got.register_address),
                          32'(want.register_address));
            compare_field("register_data", 32'(got.register_data),
                          32'(want.register_data));
            compare_field("wait_count", 32'(got.wait_count), 32'(want.wait_count));
            compare_field("jump_offset", got.jump_offset, want.jump_offset);
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [7:0]             i_stream_byte = 8'd0;
    logic                   i_stream_ended = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [1:0]             o_result_kind;
    logic [3:0]             o_write_target;
    logic                   o_write_port;
    logic [7:0]             o_register_address;
    logic [7:0]             o_register_data;
    logic [15:0]            o_wait_count;
    logic [31:0]            o_jump_offset;

    vgm_command_decoder_model decoder_model = new();
    t_result                  seen_result;
    bit                       quiet = 1'b0;
    int                       words_sent = 0;
    int                       stall_hold = 0;

    vgm_command_stream_decoder u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_stream_byte      (i_stream_byte),
        .i_stream_ended     (i_stream_ended),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_write_target     (o_write_target),
        .o_write_port       (o_write_port),
        .o_register_address (o_register_address),
        .o_register_data    (o_register_data),
        .o_wait_count       (o_wait_count),
        .o_jump_offset      (o_jump_offset)
    );

    assign seen_result = {o_result_kind, o_write_target, o_write_port, o_register_address,
                          o_register_data, o_wait_count, o_jump_offset};

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_setting(logic [31:0] top);
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        c.psg_to_ay_enable  = 1'(pick_setting(32'd1));
        c.ay_to_fm_enable   = 1'(pick_setting(32'd1));
        c.opn_to_fm_enable  = 1'(pick_setting(32'd1));
        c.source_chip_kind  = 2'(pick_setting(32'd3));
        c.loop_start_offset = pick_setting(32'hFFFF_FFFF);
        c.loop_limit        = 16'(pick_setting(32'hFFFF));
        c.wait_one_samples  = 16'(pick_setting(32'hFFFF));
        c.wait_two_samples  = 16'(pick_setting(32'hFFFF));
        return c;
    endfunction

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else if (quiet || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) decoder_model.check_result(seen_result);
    end

    task automatic send_word(input logic [7:0] b, input logic ended = 1'b0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_stream_byte <= b;
        i_stream_ended <= ended;
        do @(posedge i_clk); while (o_in_stall);
        decoder_model.note_word(b, ended);
        words_sent++;
    endtask

    // Playback must not stop before the closing part, so a stopping end opcode
    // is swapped for a preset wait.
    task automatic send_byte(input logic [7:0] b);
        send_word(decoder_model.stops_on(b) ? OP_WAIT_ONE : b);
    endtask

    task automatic send_command();
        logic [7:0] op;
        int         r;
        r = $urandom_range(0, 99);
        op = WRITE_OPS[$urandom_range(0, 7)];
        if (r < 45) begin
            send_byte(op);
            send_byte(pick_operand());
            if (op != OP_PSG) send_byte(pick_operand());
        end else if (r < 55) begin
            send_byte(OP_WAIT_WORD);
            send_byte(pick_operand());
            send_byte(pick_operand());
        end else if (r < 62) begin
            send_byte($urandom_range(0, 1) ? OP_WAIT_ONE : OP_WAIT_TWO);
        end else if (r < 75) begin
            send_byte({OP_SHORT_HI, 4'($urandom_range(0, 15))});
        end else if (r < 81) begin
            send_byte(OP_END);
        end else if (r < 88) begin
            send_byte(op);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] v);
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        decoder_model.write_reg(idx, v);
    endtask

    task automatic load_config(input t_cfg c);
        i_cfg_we <= 1'b1;
        write_reg(CFG_PSG_TO_AY, 32'(c.psg_to_ay_enable));
        write_reg(CFG_AY_TO_FM, 32'(c.ay_to_fm_enable));
        write_reg(CFG_OPN_TO_FM, 32'(c.opn_to_fm_enable));
        write_reg(CFG_SOURCE_KIND, 32'(c.source_chip_kind));
        write_reg(CFG_LOOP_START, c.loop_start_offset);
        write_reg(CFG_LOOP_LIMIT, 32'(c.loop_limit));
        write_reg(CFG_WAIT_ONE, 32'(c.wait_one_samples));
        write_reg(CFG_WAIT_TWO, 32'(c.wait_two_samples));
        i_cfg_we <= 1'b0;
    endtask

    // A word that yields no result may still sit inside the block, so the bench
    // keeps clocking after the last expected result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (decoder_model.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_cfg cfg;
        int   phase_end;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_WAIT_ONE);
        send_word(OP_WAIT_TWO);
        send_word(OP_PSG);
        send_word(8'hFF);
        send_word(OP_OPN2_P0);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(OP_WAIT_WORD);
        send_word(8'h00);
        send_word(8'h00);
        send_word({OP_SHORT_HI, 4'h0});
        send_word({OP_SHORT_HI, SHORT_MASK});
        send_word(8'hFF);

        settle();
        cfg.psg_to_ay_enable  = 1'b1;
        cfg.ay_to_fm_enable   = 1'b1;
        cfg.opn_to_fm_enable  = 1'b1;
        cfg.source_chip_kind  = SRC_OPN2;
        cfg.loop_start_offset = 32'hFFFF_FFFF;
        cfg.loop_limit        = 16'd0;
        cfg.wait_one_samples  = 16'd0;
        cfg.wait_two_samples  = 16'hFFFF;
        load_config(cfg);
        send_word(OP_PSG);
        send_word(8'h00);
        send_word(OP_AY);
        send_word(8'hFF);
        send_word(8'h00);
        send_word(OP_OPN2_P1);
        send_word(8'h80);
        send_word(8'h01);
        send_word(OP_OPM);
        send_word(8'h12);
        send_word(8'h34);
        send_word(OP_OPN);
        send_word(8'h56);
        send_word(8'h78);
        send_word(OP_OPNA_P1);
        send_word(8'h9A);
        send_word(8'hBC);
        send_word(OP_END);
        send_word(OP_WAIT_ONE);
        send_word(OP_WAIT_TWO);

        while (words_sent < WORD_TARGET) begin
            settle();
            load_config(random_config());
            quiet = ($urandom_range(0, 3) == 0);
            phase_end = words_sent + $urandom_range(120, 260);
            while (words_sent < phase_end && words_sent < WORD_TARGET) send_command();
        end

        // Playback stops only once per run, so one way of stopping is chosen here.
        settle();
        quiet = 1'b0;
        cfg = decoder_model.regs;
        case ($urandom_range(0, 3))
            0: begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                send_word(OP_OPN2_P0);
                repeat ($urandom_range(0, 1)) send_word(pick_operand());
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            2: begin
                cfg.loop_start_offset = $urandom_range(1, 32'hFFFF_FFFF);
                cfg.loop_limit = decoder_model.pass_count + 16'd2;
                load_config(cfg);
                repeat (3) send_word(OP_END);
            end
            default: begin
                cfg.loop_start_offset = 32'd0;
                load_config(cfg);
                send_word(OP_END);
            end
        endcase
        repeat (20) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        settle();
        repeat (10) @(posedge i_clk);
        if (decoder_model.mismatches == 0 && decoder_model.expected_results.size() == 0)
            $display("vgm_command_stream_decoder test passed");
        else
            $display("vgm_command_stream_decoder test failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("vgm_command_stream_decoder test failed");
        $finish;
    end

endmodule
